### rtl/rau_pkg.sv
// Package for the rational arithmetic unit: opcodes, field widths and sequencer codes.
package rau_pkg;
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam int NUM_W = 61;
  localparam int DEN_W = 60;
  localparam int ACC_W = 62;
  localparam int CNT_W = 6;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_COMB = 4'd2;
  localparam logic [3:0] ST_GCD  = 4'd3;
  localparam logic [3:0] ST_DIVN = 4'd4;
  localparam logic [3:0] ST_DIVD = 4'd5;
  localparam logic [3:0] ST_OUT  = 4'd6;
endpackage

### rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: shared shift/add/subtract datapath under a sequencer.
//
//  channel | dir | tdata fields (low bit first)                         | tuser
//  in_     | in  | a_neg, a_num, a_den, b_neg, b_num, b_den             | kind
//  out_    | out | res_neg, res_num, res_den, greater, equal, less, error | -
//
//  Each item runs four shift-add products, a combine step, the binary gcd and the two
//  divisions by the gcd; one shared 62-bit adder/subtractor serves all of these, with
//  separate subtractors for some combine and gcd cases.
//  rst_n is synchronous and active low; it clears the sequencer and out_tvalid.
//  in_tready is high only in the idle state; a stalled result holds the unit.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int MAG_BITS = 30
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // a_neg, a_num, a_den, b_neg, b_num, b_den
  input  logic [4*MAG_BITS+1+((8-((4*MAG_BITS+2)%8))%8):0] in_tdata,
  // kind
  input  logic [2:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // res_neg, res_num, res_den, greater, equal, less, error
  output logic [127:0]  out_tdata
);
  localparam int M = MAG_BITS;
  localparam int MC_W = $clog2(M+1);
  localparam logic [CNT_W:0] DC_END = (CNT_W+1)'(ACC_W);

  logic [3:0] st_r, st_nxt;
  logic [2:0] kind_r;
  logic       an_r, bn_r;
  logic [M-1:0] ap_r, aq_r, bp_r, bq_r;
  // multiplier state
  logic [1:0] mi_r;
  logic [MC_W-1:0] mc_r;
  logic [ACC_W-1:0] acc_r, xa_r, xb_r, dd_r, nm_r;
  logic [M-1:0] mpl_r;
  logic [ACC_W-1:0] mcd_r;
  // gcd state
  logic [ACC_W-1:0] gu_r, gv_r;
  logic [CNT_W:0] gk_r;
  // divider state
  logic [ACC_W-1:0] q_r, rem_r;
  logic [CNT_W:0] dc_r;
  logic [ACC_W-1:0] g_r;
  // result
  logic neg_r, gt_r, eq_r, lt_r, err_r;
  logic [NUM_W-1:0] rn_r;
  logic [DEN_W-1:0] rd_r;

  // shared adder
  logic [ACC_W-1:0] add_a, add_b, add_s;
  logic add_sub;
  logic [ACC_W:0] add_full;
  always_comb begin
    add_full = add_sub ? ({1'b0, add_a} + {1'b0, ~add_b} + {{ACC_W{1'b0}}, 1'b1})
                       : ({1'b0, add_a} + {1'b0, add_b});
    add_s = add_full[ACC_W-1:0];
  end
  // for subtract, carry out set means a >= b
  logic add_ge;
  assign add_ge = add_full[ACC_W];

  logic [M-1:0] in_ap, in_aq, in_bp, in_bq;
  assign in_ap = in_tdata[M:1];
  assign in_aq = in_tdata[2*M:M+1];
  assign in_bp = in_tdata[3*M+1:2*M+2];
  assign in_bq = in_tdata[4*M+1:3*M+2];

  logic in_err;
  assign in_err = (in_tuser <= OP_CMP) && (in_aq == '0 || in_bq == '0 ||
                  (in_tuser == OP_DIV && in_bp == '0));

  assign in_tready = (st_r == ST_IDLE);
  assign out_tvalid = (st_r == ST_OUT);

  // signs, seen once products are ready
  logic sa, sb, sbe;
  assign sa = an_r && ap_r != '0;
  assign sb = bn_r && bp_r != '0;
  assign sbe = (kind_r == OP_SUB) ? (bp_r != '0 && !sb) : sb;

  always_comb begin
    add_a = acc_r;
    add_b = mcd_r;
    add_sub = 1'b0;
    case (st_r)
      ST_MUL: begin
        add_a = acc_r; add_b = mcd_r; add_sub = 1'b0;
      end
      ST_COMB: begin
        add_a = xa_r; add_b = xb_r;
        add_sub = !((kind_r == OP_ADD || kind_r == OP_SUB) && sa == sbe);
      end
      ST_GCD: begin
        add_a = gu_r; add_b = gv_r; add_sub = 1'b1;
      end
      ST_DIVN, ST_DIVD: begin
        add_a = {rem_r[ACC_W-2:0], q_r[ACC_W-1]}; add_b = g_r; add_sub = 1'b1;
      end
      default: begin
        add_a = acc_r; add_b = mcd_r; add_sub = 1'b0;
      end
    endcase
  end

  // operands of the first three products: 0 xa=ap*bq, 1 xb=bp*aq, 2 nm=ap*bp (zero unless multiply)
  function automatic logic [2*M-1:0] sel_ops(input logic [1:0] i, input logic [2:0] k,
      input logic [M-1:0] ap, aq, bp, bq);
    logic [2*M-1:0] r;
    r = {ap, bq};
    case (i)
      2'd0: r = {ap, bq};
      2'd1: r = {bp, aq};
      2'd2: r = (k == OP_MUL) ? {ap, bp} : '0;
      default: r = {ap, bq};
    endcase
    return r;
  endfunction

  logic [2*M-1:0] ops;
  logic [M-1:0] dmul_a, dmul_b;
  always_comb begin
    ops = sel_ops(mi_r, kind_r, ap_r, aq_r, bp_r, bq_r);
    dmul_a = aq_r;
    dmul_b = (kind_r == OP_DIV) ? bp_r : bq_r;
  end

  logic gu_odd, gv_odd;
  assign gu_odd = gu_r[0];
  assign gv_odd = gv_r[0];

  function automatic logic [ACC_W-1:0] add_comb_mag();
    logic [ACC_W-1:0] r;
    if (sa == sbe) r = add_s;
    else if (add_ge && xa_r != xb_r) r = add_s;
    else r = xb_r - xa_r;
    return r;
  endfunction

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_tvalid) st_nxt = ST_MUL;
      ST_MUL: if (mi_r == 2'd3 && mc_r == MC_W'(M)) st_nxt = ST_COMB;
      ST_COMB: st_nxt = ST_GCD;
      ST_GCD: if (gv_r == '0 || gu_r == '0) st_nxt = ST_DIVN;
      ST_DIVN: if (dc_r == DC_END) st_nxt = ST_DIVD;
      ST_DIVD: if (dc_r == DC_END) st_nxt = ST_OUT;
      ST_OUT: if (out_tready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        kind_r <= in_tuser;
        an_r <= in_tdata[0];
        bn_r <= in_tdata[2*M+1];
        ap_r <= in_ap; aq_r <= in_aq; bp_r <= in_bp; bq_r <= in_bq;
        err_r <= in_err;
        mi_r <= 2'd0; mc_r <= '0; acc_r <= '0;
        gt_r <= 1'b0; eq_r <= 1'b0; lt_r <= 1'b0;
      end
      ST_MUL: begin
        // shift-add: multiplier bit LSB first, multiplicand shifted left
        if (mc_r == '0) begin
          if (mi_r == 2'd3) begin
            mcd_r <= ACC_W'(dmul_a);
            mpl_r <= dmul_b;
          end else begin
            mcd_r <= ACC_W'(ops[2*M-1:M]);
            mpl_r <= ops[M-1:0];
          end
          acc_r <= '0;
          mc_r <= mc_r + 1'b1;
        end else if (mc_r == MC_W'(M)) begin
          case (mi_r)
            2'd0: xa_r <= (mpl_r[0] ? add_s : acc_r);
            2'd1: xb_r <= (mpl_r[0] ? add_s : acc_r);
            2'd2: nm_r <= (mpl_r[0] ? add_s : acc_r);
            default: dd_r <= (mpl_r[0] ? add_s : acc_r);
          endcase
          mi_r <= mi_r + 1'b1;
          mc_r <= '0;
        end else begin
          acc_r <= mpl_r[0] ? add_s : acc_r;
          mpl_r <= mpl_r >> 1;
          mcd_r <= mcd_r << 1;
          mc_r <= mc_r + 1'b1;
        end
      end
      ST_COMB: begin
        case (kind_r)
          OP_ADD, OP_SUB: begin
            if (sa == sbe) begin
              nm_r <= add_s; neg_r <= sa;
            end else if (add_ge && xa_r != xb_r) begin
              nm_r <= add_s; neg_r <= sa;
            end else begin
              nm_r <= xb_r - xa_r; neg_r <= sbe;
            end
          end
          OP_MUL: neg_r <= an_r != bn_r;
          OP_DIV: begin
            nm_r <= xa_r; neg_r <= an_r != bn_r;
          end
          OP_CMP: begin
            nm_r <= '0;
            neg_r <= 1'b0;
            if (!err_r) begin
              if (sa != sb) begin
                gt_r <= sb; lt_r <= sa;
              end else if (xa_r == xb_r) begin
                eq_r <= 1'b1;
              end else begin
                gt_r <= add_ge != sa; lt_r <= !(add_ge != sa);
              end
            end
          end
          default: begin
            nm_r <= '0;
            neg_r <= 1'b0;
          end
        endcase
        gk_r <= '0;
      end
      ST_GCD: begin
        if (gv_r != '0 && gu_r != '0) begin
          if (!gu_odd && !gv_odd) begin
            gu_r <= gu_r >> 1; gv_r <= gv_r >> 1; gk_r <= gk_r + 1'b1;
          end else if (!gu_odd) begin
            gu_r <= gu_r >> 1;
          end else if (!gv_odd) begin
            gv_r <= gv_r >> 1;
          end else if (add_ge) begin
            gu_r <= gv_r; gv_r <= add_s >> 1;
          end else begin
            gv_r <= (gv_r - gu_r) >> 1;
          end
        end else begin
          // a zero numerator needs no reduction: divide by one
          g_r <= (gu_r == '0) ? ACC_W'(1) : (gu_r << gk_r);
          q_r <= nm_r; rem_r <= '0; dc_r <= '0;
        end
      end
      ST_DIVN, ST_DIVD: begin
        if (dc_r == DC_END) begin
          if (st_r == ST_DIVN) begin
            rn_r <= q_r[NUM_W-1:0];
            q_r <= dd_r; rem_r <= '0; dc_r <= '0;
          end else begin
            rd_r <= q_r[DEN_W-1:0];
          end
        end else begin
          q_r <= {q_r[ACC_W-2:0], add_ge};
          rem_r <= add_ge ? add_s : add_a;
          dc_r <= dc_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
    // load gcd operands at end of combine
    if (st_r == ST_COMB) begin
      gu_r <= ((kind_r == OP_ADD || kind_r == OP_SUB) ? add_comb_mag()
               : (kind_r == OP_DIV ? xa_r : nm_r));
      gv_r <= dd_r;
    end
  end

  // output formatting
  logic zero_res, arith;
  logic o_neg;
  logic [NUM_W-1:0] o_num;
  logic [DEN_W-1:0] o_den;
  always_comb begin
    arith = kind_r <= OP_DIV;
    zero_res = (rn_r == '0);
    o_neg = 1'b0; o_num = '0; o_den = DEN_W'(1);
    if (err_r) begin
      o_den = '0;
    end else if (kind_r == OP_CMP) begin
      o_den = '0;
    end else if (arith && !zero_res) begin
      o_neg = neg_r; o_num = rn_r; o_den = rd_r;
    end
  end
  assign out_tdata = {{(128-NUM_W-DEN_W-5){1'b0}}, err_r, lt_r, eq_r, gt_r, o_den, o_num, o_neg};

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("ready while result pending");
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $countones({gt_r, eq_r, lt_r}) <= 1) else $error("several compare flags");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
`endif
endmodule

### tb/sv/tb_top.sv
// Testbench for the rational arithmetic unit: random and directed fraction requests checked
// against an in-bench predictor.
`timescale 1ns / 100ps

module tb_top;
  import rau_pkg::*;

  localparam int MB = 30;
  localparam int IN_W = 4*MB+2+((8-((4*MB+2)%8))%8);

  typedef struct packed {
    logic        err;
    logic        lt;
    logic        eq;
    logic        gt;
    logic [59:0] den;
    logic [60:0] num;
    logic        neg;
  } res_t;

  class frac_scoreboard;
    res_t pending[$];
    int   errors;

    function logic [63:0] gcd(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      return x;
    endfunction

    function void note_request(logic [2:0] op, logic an, logic [29:0] ap, logic [29:0] aq,
                               logic bn, logic [29:0] bp, logic [29:0] bq);
      res_t r;
      logic [63:0] xa, xb, num, den, g;
      logic sa, sb, sbe, neg;
      r = '0;
      num = 0;
      den = 1;
      neg = 0;
      sa = an && ap != 0;
      sb = bn && bp != 0;
      xa = 64'(ap) * bq;
      xb = 64'(bp) * aq;
      if (op <= OP_CMP && (aq == 0 || bq == 0 || (op == OP_DIV && bp == 0))) begin
        r.err = 1;
        den = 0;
      end else if (op == OP_ADD || op == OP_SUB) begin
        sbe = (op == OP_SUB) ? (bp != 0 && !sb) : sb;
        den = 64'(aq) * bq;
        if (sa == sbe) begin
          num = xa + xb;
          neg = sa;
        end else if (xa > xb) begin
          num = xa - xb;
          neg = sa;
        end else begin
          num = xb - xa;
          neg = sbe;
        end
      end else if (op == OP_MUL) begin
        num = 64'(ap) * bp;
        den = 64'(aq) * bq;
        neg = an != bn;
      end else if (op == OP_DIV) begin
        num = xa;
        den = 64'(aq) * bp;
        neg = an != bn;
      end else if (op == OP_CMP) begin
        den = 0;
        if (sa != sb) begin
          r.gt = sb;
          r.lt = sa;
        end else if (xa == xb) begin
          r.eq = 1;
        end else begin
          r.gt = (xa > xb) != sa;
          r.lt = !r.gt;
        end
      end
      if (!r.err && op <= OP_DIV) begin
        if (num == 0) begin
          den = 1;
          neg = 0;
        end else begin
          g = gcd(num, den);
          num = num / g;
          den = den / g;
        end
      end
      r.neg = neg;
      r.num = num[60:0];
      r.den = den[59:0];
      pending.push_back(r);
    endfunction

    function void check_result(res_t act);
      res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, act);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.neg != act.neg) begin
        $display("%0t: res_neg exp %0d got %0d", $time, e.neg, act.neg); errors++;
      end
      if (e.num != act.num) begin
        $display("%0t: res_num exp %0d got %0d", $time, e.num, act.num); errors++;
      end
      if (e.den != act.den) begin
        $display("%0t: res_den exp %0d got %0d", $time, e.den, act.den); errors++;
      end
      if (e.gt != act.gt) begin
        $display("%0t: greater exp %0d got %0d", $time, e.gt, act.gt); errors++;
      end
      if (e.eq != act.eq) begin
        $display("%0t: equal exp %0d got %0d", $time, e.eq, act.eq); errors++;
      end
      if (e.lt != act.lt) begin
        $display("%0t: less exp %0d got %0d", $time, e.lt, act.lt); errors++;
      end
      if (e.err != act.err) begin
        $display("%0t: error exp %0d got %0d", $time, e.err, act.err); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [127:0] out_tdata;

  frac_scoreboard sb = new();
  int send_idle = 14;
  int recv_idle = 72;
  int cycles = 0;

  rational_arithmetic_unit #(.MAG_BITS(MB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial forever #6 clk = ~clk;

  // receiver: stall at random, check each accepted result
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) sb.check_result(res_t'(out_tdata[125:0]));
    out_tready <= ($urandom_range(99) >= recv_idle);
    if (cycles > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // hold tvalid across back-to-back requests; drop it only while idling
  task automatic send_request(logic [2:0] op, logic an, logic [29:0] ap, logic [29:0] aq,
                              logic bn, logic [29:0] bp, logic [29:0] bq);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= IN_W'({bq, bp, bn, aq, ap, an});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, an, ap, aq, bn, bp, bq);
  endtask

  function automatic logic [29:0] rand_mag();
    case ($urandom_range(5))
      0: return 30'($urandom_range(3));
      1: return 30'($urandom_range(1000));
      2: return 30'($urandom_range(1000000000));
      3: return 30'h3fff_ffff - 30'($urandom_range(3));
      4: return 30'(1 << $urandom_range(29));
      default: return 30'($urandom);
    endcase
  endfunction

  task automatic random_request();
    logic [29:0] aq, bq, bp;
    logic [2:0] op;
    op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    aq = rand_mag();
    bq = rand_mag();
    bp = rand_mag();
    if ($urandom_range(9) != 0) begin
      if (aq == 0) aq = 1;
      if (bq == 0) bq = 7;
    end
    // reuse one operand now and then so compares hit equality
    if ($urandom_range(7) == 0) send_request(op, 1'($urandom), bp, bq, 1'($urandom), bp, bq);
    else send_request(op, 1'($urandom), rand_mag(), aq, 1'($urandom), bp, bq);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  initial begin
    logic [2:0] op;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int k = 0; k < 8; k++) begin
      op = 3'(k);
      send_request(op, 1, 30'd1000000000, 30'd1000000000, 0, 30'd1, 30'd999999999);
    end
    send_request(OP_ADD, 1, 0, 5, 0, 0, 3);            // negative zero operands
    send_request(OP_SUB, 0, 2, 4, 0, 1, 2);            // difference is zero
    send_request(OP_MUL, 1, 30'h3fffffff, 1, 1, 30'h3fffffff, 1);
    send_request(OP_DIV, 0, 3, 4, 1, 0, 5);            // divide by zero
    send_request(OP_ADD, 0, 1, 0, 0, 1, 1);            // zero denominator
    send_request(OP_CMP, 0, 1, 1, 0, 1, 0);
    send_request(OP_CMP, 1, 2, 4, 0, 1, 2);
    send_request(OP_CMP, 1, 1, 2, 1, 2, 4);
    send_request(OP_CMP, 1, 0, 3, 0, 0, 9);
    send_request(OP_CMP, 0, 3, 7, 0, 2, 7);
    send_request(OP_DIV, 1, 1000000000, 1, 0, 1, 1000000000);
    send_request(OP_SUB, 1, 7, 3, 1, 9, 3);
    drain();                                           // hold until all results are in
    for (int i = 0; i < 520; i++) random_request();
    send_idle = 72;
    recv_idle = 14;
    for (int i = 0; i < 520; i++) random_request();
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 510; i++) random_request();
    drain();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
